@@ rtl/dmc_pkg.sv @@
package dmc_pkg;

   localparam int unsigned OVERRUN_WIDTH = 16;

   typedef enum logic [2:0] {
      CMD_TICK        = 3'd0,
      CMD_OVERRIDE    = 3'd1,
      CMD_OPEN        = 3'd2,
      CMD_CLOSE       = 3'd3,
      CMD_MARK_OPEN   = 3'd4,
      CMD_MARK_CLOSED = 3'd5
   } command_type;

   typedef enum logic [2:0] {
      DOOR_OPEN          = 3'd0,
      DOOR_CLOSED        = 3'd1,
      DOOR_OPENING       = 3'd2,
      DOOR_CLOSING       = 3'd3,
      DOOR_STOP_OPENING  = 3'd4,
      DOOR_STOP_CLOSING  = 3'd5,
      DOOR_UNKNOWN       = 3'd6
   } door_type;

   typedef enum logic [1:0] {
      DRIVE_STOP    = 2'd0,
      DRIVE_FORWARD = 2'd1,
      DRIVE_REVERSE = 2'd2
   } drive_type;

   typedef struct packed {
      logic [2:0] command;
      logic       open_switch;
      logic       closed_switch;
   } req_type;

   typedef struct packed {
      logic [1:0] motor_drive;
      logic [2:0] door_status;
      logic       in_overrun;
   } rsp_type;

   typedef struct packed {
      door_type                 door;
      drive_type                motor;
      logic [OVERRUN_WIDTH-1:0] overrun_left;
      logic                     overrun_active;
   } state_type;

endpackage

@@ rtl/dmc_next_state.sv @@
module dmc_next_state (
   input  dmc_pkg::state_type                    cur_state,
   input  dmc_pkg::req_type                      item,
   input  logic [dmc_pkg::OVERRUN_WIDTH-1:0]     overrun_ticks,
   output dmc_pkg::state_type                    next_state
);

   logic [dmc_pkg::OVERRUN_WIDTH-1:0] left_dec;
   dmc_pkg::door_type                 end_door;
   logic                              limit_hit;

   assign left_dec = cur_state.overrun_left - 1'b1;
   assign end_door = (cur_state.door == dmc_pkg::DOOR_CLOSING) ?
                     dmc_pkg::DOOR_CLOSED : dmc_pkg::DOOR_OPEN;
   assign limit_hit = ((cur_state.door == dmc_pkg::DOOR_OPENING) && item.open_switch) ||
                      ((cur_state.door == dmc_pkg::DOOR_CLOSING) && item.closed_switch);

   always_comb begin
      next_state = cur_state;
      if (dmc_pkg::command_type'(item.command) == dmc_pkg::CMD_TICK) begin
         if (cur_state.overrun_active) begin
            next_state.overrun_left = left_dec;
            if (left_dec == '0) begin
               next_state.overrun_active = 1'b0;
               next_state.door           = end_door;
               next_state.motor          = dmc_pkg::DRIVE_STOP;
            end
         end else if (limit_hit) begin
            if (overrun_ticks == '0) begin
               next_state.door  = end_door;
               next_state.motor = dmc_pkg::DRIVE_STOP;
            end else begin
               next_state.overrun_left   = overrun_ticks;
               next_state.overrun_active = 1'b1;
            end
         end else if (cur_state.door == dmc_pkg::DOOR_UNKNOWN) begin
            if (!item.open_switch) begin
               next_state.door  = dmc_pkg::DOOR_OPENING;
               next_state.motor = dmc_pkg::DRIVE_FORWARD;
            end else begin
               next_state.door = dmc_pkg::DOOR_OPEN;
            end
         end
      end else if (!cur_state.overrun_active) begin
         case (dmc_pkg::command_type'(item.command))
            dmc_pkg::CMD_OVERRIDE: begin
               if (cur_state.door inside {dmc_pkg::DOOR_OPEN, dmc_pkg::DOOR_STOP_OPENING}) begin
                  if (!item.closed_switch) begin
                     next_state.door  = dmc_pkg::DOOR_CLOSING;
                     next_state.motor = dmc_pkg::DRIVE_REVERSE;
                  end else begin
                     next_state.door  = dmc_pkg::DOOR_CLOSED;
                     next_state.motor = dmc_pkg::DRIVE_STOP;
                  end
               end else if (cur_state.door inside {dmc_pkg::DOOR_CLOSED,
                                                   dmc_pkg::DOOR_STOP_CLOSING,
                                                   dmc_pkg::DOOR_UNKNOWN}) begin
                  if (!item.open_switch) begin
                     next_state.door  = dmc_pkg::DOOR_OPENING;
                     next_state.motor = dmc_pkg::DRIVE_FORWARD;
                  end else begin
                     next_state.door  = dmc_pkg::DOOR_OPEN;
                     next_state.motor = dmc_pkg::DRIVE_STOP;
                  end
               end else if (cur_state.door == dmc_pkg::DOOR_OPENING) begin
                  next_state.door  = dmc_pkg::DOOR_STOP_OPENING;
                  next_state.motor = dmc_pkg::DRIVE_STOP;
               end else if (cur_state.door == dmc_pkg::DOOR_CLOSING) begin
                  next_state.door  = dmc_pkg::DOOR_STOP_CLOSING;
                  next_state.motor = dmc_pkg::DRIVE_STOP;
               end
            end
            dmc_pkg::CMD_OPEN: begin
               if (!item.open_switch) begin
                  next_state.door  = dmc_pkg::DOOR_OPENING;
                  next_state.motor = dmc_pkg::DRIVE_FORWARD;
               end else begin
                  next_state.door  = dmc_pkg::DOOR_OPEN;
                  next_state.motor = dmc_pkg::DRIVE_STOP;
               end
            end
            dmc_pkg::CMD_CLOSE: begin
               if (!item.closed_switch) begin
                  next_state.door  = dmc_pkg::DOOR_CLOSING;
                  next_state.motor = dmc_pkg::DRIVE_REVERSE;
               end else begin
                  next_state.door  = dmc_pkg::DOOR_CLOSED;
                  next_state.motor = dmc_pkg::DRIVE_STOP;
               end
            end
            dmc_pkg::CMD_MARK_OPEN: begin
               next_state.door  = dmc_pkg::DOOR_OPEN;
               next_state.motor = dmc_pkg::DRIVE_STOP;
            end
            dmc_pkg::CMD_MARK_CLOSED: begin
               next_state.door  = dmc_pkg::DOOR_CLOSED;
               next_state.motor = dmc_pkg::DRIVE_STOP;
            end
            default: begin
               next_state = cur_state;
            end
         endcase
      end
   end

endmodule

@@ rtl/door_motor_controller.sv @@
// Door motor controller.
// Request channel (req_valid/req_ready/req_item) takes one beat per command:
// tick, override press, open, close, mark open or mark closed, together with
// the debounced open and closed limit switch levels.
// Response channel (rsp_valid/rsp_ready/rsp_item) returns one beat per
// request: motor drive, door status and the overrun flag after the update.
// csr_write_enable/csr_write_data load the overrun tick count; write it only
// while no request is in flight.
// A request accepted into the input register is processed by the state update
// once the response register is free or being drained; its response is then
// valid in the response register. Throughput: one beat per cycle while rsp_ready
// is high; the update is combinational logic between the input and response registers.
// Reset clears both stages, sets the door to unknown, stops the motor, ends
// any overrun and zeroes the overrun tick count.
// When rsp_ready is low the response register holds, the input register
// still fills, and req_ready drops only once both are occupied.
module door_motor_controller (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  dmc_pkg::req_type                     req_item,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output dmc_pkg::rsp_type                     rsp_item,
   input  logic                                 csr_write_enable,
   input  logic [dmc_pkg::OVERRUN_WIDTH-1:0]    csr_write_data
);

   logic                              in_valid_ff;
   dmc_pkg::req_type                  in_item_ff;
   logic                              rsp_valid_ff;
   dmc_pkg::rsp_type                  rsp_item_ff;
   dmc_pkg::state_type                state_ff;
   dmc_pkg::state_type                state_in;
   logic [dmc_pkg::OVERRUN_WIDTH-1:0] overrun_ticks_ff;
   logic                              advance;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   dmc_next_state u_next (
      .cur_state     (state_ff),
      .item          (in_item_ff),
      .overrun_ticks (overrun_ticks_ff),
      .next_state    (state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff                 <= 1'b0;
         rsp_valid_ff                <= 1'b0;
         overrun_ticks_ff            <= '0;
         state_ff.door               <= dmc_pkg::DOOR_UNKNOWN;
         state_ff.motor              <= dmc_pkg::DRIVE_STOP;
         state_ff.overrun_left       <= '0;
         state_ff.overrun_active     <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            overrun_ticks_ff <= csr_write_data;
         end
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         rsp_item_ff.motor_drive <= state_in.motor;
         rsp_item_ff.door_status <= state_in.door;
         rsp_item_ff.in_overrun  <= state_in.overrun_active;
      end
   end

endmodule
